FILE: rtl/core/pcpo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpo_pkg
// Shared types and constants for the pixel color point operation block.
// ----------------------------------------------------------------------------
package pcpo_pkg;

    localparam int GAIN_W          = 16;
    localparam int PIX_W           = 8;
    localparam int GAIN_FRAC_BITS  = 8;
    localparam int QUEUE_DEPTH     = 4;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 32;
    localparam int TABLE_DEPTH     = 256;

    localparam logic [1:0]        OP_MODE_RESET   = 2'd1;
    localparam logic              HAS_ALPHA_RESET = 1'b1;
    localparam logic [GAIN_W-1:0] GAIN_RESET      = 16'd256;

    // op_mode codes
    localparam logic [1:0] MODE_LUT      = 2'd0;
    localparam logic [1:0] MODE_SCALE    = 2'd1;
    localparam logic [1:0] MODE_OFFSET   = 2'd2;
    localparam logic [1:0] MODE_CONTRAST = 2'd3;

    // table_channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [2:0] {
        REG_OP_MODE    = 3'd0,
        REG_HAS_ALPHA  = 3'd1,
        REG_GAIN_RED   = 3'd2,
        REG_GAIN_GREEN = 3'd3,
        REG_GAIN_BLUE  = 3'd4,
        REG_GAIN_ALPHA = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_LUT,
        OP_SCALE,
        OP_OFFSET,
        OP_CONTRAST
    } t_op;

    typedef struct packed {
        logic [1:0]               op_mode;
        logic                     has_alpha;
        logic signed [GAIN_W-1:0] gain_red;
        logic signed [GAIN_W-1:0] gain_green;
        logic signed [GAIN_W-1:0] gain_blue;
        logic signed [GAIN_W-1:0] gain_alpha;
    } t_cfg;

    typedef struct packed {
        t_op              op;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic             last;
        logic [1:0]       tbl_channel;
        logic [PIX_W-1:0] tbl_index;
        logic [PIX_W-1:0] tbl_value;
    } t_req;

endpackage

FILE: rtl/core/pcpo_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpo_regs
// APB configuration registers: mode, alpha enable and four Q gains.
// ----------------------------------------------------------------------------
module pcpo_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcpo_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pcpo_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pcpo_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output pcpo_pkg::t_cfg                    o_cfg
);

    pcpo_pkg::t_cfg     r_cfg;
    pcpo_pkg::t_cfg     n_cfg;
    pcpo_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = pcpo_pkg::t_reg_idx'(paddr[pcpo_pkg::APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                pcpo_pkg::REG_OP_MODE:    n_cfg.op_mode    = pwdata[1:0];
                pcpo_pkg::REG_HAS_ALPHA:  n_cfg.has_alpha  = pwdata[0];
                pcpo_pkg::REG_GAIN_RED:   n_cfg.gain_red   = pwdata[pcpo_pkg::GAIN_W-1:0];
                pcpo_pkg::REG_GAIN_GREEN: n_cfg.gain_green = pwdata[pcpo_pkg::GAIN_W-1:0];
                pcpo_pkg::REG_GAIN_BLUE:  n_cfg.gain_blue  = pwdata[pcpo_pkg::GAIN_W-1:0];
                pcpo_pkg::REG_GAIN_ALPHA: n_cfg.gain_alpha = pwdata[pcpo_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            pcpo_pkg::REG_OP_MODE:    prdata = {30'd0, r_cfg.op_mode};
            pcpo_pkg::REG_HAS_ALPHA:  prdata = {31'd0, r_cfg.has_alpha};
            pcpo_pkg::REG_GAIN_RED:   prdata = {{16{r_cfg.gain_red[15]}}, r_cfg.gain_red};
            pcpo_pkg::REG_GAIN_GREEN: prdata = {{16{r_cfg.gain_green[15]}}, r_cfg.gain_green};
            pcpo_pkg::REG_GAIN_BLUE:  prdata = {{16{r_cfg.gain_blue[15]}}, r_cfg.gain_blue};
            pcpo_pkg::REG_GAIN_ALPHA: prdata = {{16{r_cfg.gain_alpha[15]}}, r_cfg.gain_alpha};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.op_mode    <= pcpo_pkg::OP_MODE_RESET;
            r_cfg.has_alpha  <= pcpo_pkg::HAS_ALPHA_RESET;
            r_cfg.gain_red   <= pcpo_pkg::GAIN_RESET;
            r_cfg.gain_green <= pcpo_pkg::GAIN_RESET;
            r_cfg.gain_blue  <= pcpo_pkg::GAIN_RESET;
            r_cfg.gain_alpha <= pcpo_pkg::GAIN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/pcpo_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpo_front
// Accepts input requests, classifies them by command and mode, and registers
// them for the queue.
// ----------------------------------------------------------------------------
module pcpo_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [pcpo_pkg::PIX_W-1:0]    i_red_in,
    input  logic [pcpo_pkg::PIX_W-1:0]    i_green_in,
    input  logic [pcpo_pkg::PIX_W-1:0]    i_blue_in,
    input  logic [pcpo_pkg::PIX_W-1:0]    i_alpha_in,
    input  logic                          i_frame_end,
    input  logic [1:0]                    i_table_channel,
    input  logic [pcpo_pkg::PIX_W-1:0]    i_table_index,
    input  logic [pcpo_pkg::PIX_W-1:0]    i_table_value,
    input  logic [1:0]                    i_op_mode,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output pcpo_pkg::t_req                o_q_data
);

    logic           r_valid;
    logic           n_valid;
    pcpo_pkg::t_req r_req;
    pcpo_pkg::t_req n_req;
    logic           w_accept;

    assign o_in_stall = r_valid && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_q_push   = r_valid && !i_q_full;
    assign o_q_data   = r_req;

    always_comb begin
        n_req.red         = i_red_in;
        n_req.green       = i_green_in;
        n_req.blue        = i_blue_in;
        n_req.alpha       = i_alpha_in;
        n_req.last        = i_frame_end;
        n_req.tbl_channel = i_table_channel;
        n_req.tbl_index   = i_table_index;
        n_req.tbl_value   = i_table_value;
        if (i_command == pcpo_pkg::CMD_WRITE) begin
            n_req.op = pcpo_pkg::OP_WRITE;
        end else begin
            unique case (i_op_mode)
                pcpo_pkg::MODE_LUT:      n_req.op = pcpo_pkg::OP_LUT;
                pcpo_pkg::MODE_SCALE:    n_req.op = pcpo_pkg::OP_SCALE;
                pcpo_pkg::MODE_OFFSET:   n_req.op = pcpo_pkg::OP_OFFSET;
                pcpo_pkg::MODE_CONTRAST: n_req.op = pcpo_pkg::OP_CONTRAST;
                default:                 n_req.op = pcpo_pkg::OP_SCALE;
            endcase
        end
        n_valid = w_accept || (r_valid && i_q_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= n_req;
        end
    end

    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_q_full |=> r_valid && $stable(r_req))
        else $error("front request lost while queue full");

endmodule

FILE: rtl/core/pcpo_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpo_queue
// Small request queue between the front and back parts.
// ----------------------------------------------------------------------------
module pcpo_queue #(
    parameter int Depth = pcpo_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pcpo_pkg::t_req i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pcpo_pkg::t_req o_data
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    pcpo_pkg::t_req  r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_count;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty queue");

endmodule

FILE: rtl/core/pcpo_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpo_back
// Executes queued requests: table writes and reads, gain multiply, offset
// add, contrast scale, then saturation into the output register.
// ----------------------------------------------------------------------------
module pcpo_back #(
    parameter int GainFracBits = pcpo_pkg::GAIN_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcpo_pkg::t_cfg                i_cfg,
    input  logic                          i_q_valid,
    input  pcpo_pkg::t_req                i_q_data,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pcpo_pkg::PIX_W-1:0]    o_red_out,
    output logic [pcpo_pkg::PIX_W-1:0]    o_green_out,
    output logic [pcpo_pkg::PIX_W-1:0]    o_blue_out,
    output logic [pcpo_pkg::PIX_W-1:0]    o_alpha_out,
    output logic                          o_last_out
);

    localparam int PixW  = pcpo_pkg::PIX_W;
    localparam int GainW = pcpo_pkg::GAIN_W;
    localparam int ProdW = PixW + 1 + GainW;
    localparam int AccW  = (GainFracBits + PixW + 2 > ProdW + 1) ?
                           GainFracBits + PixW + 2 : ProdW + 1;
    localparam int Lanes = 4;

    logic [PixW-1:0] r_tbl_red   [pcpo_pkg::TABLE_DEPTH];
    logic [PixW-1:0] r_tbl_green [pcpo_pkg::TABLE_DEPTH];
    logic [PixW-1:0] r_tbl_blue  [pcpo_pkg::TABLE_DEPTH];

    logic                   w_adv;
    logic                   w_wr;
    logic [PixW-1:0]        w_x    [Lanes];
    logic signed [GainW-1:0] w_g   [Lanes];
    logic signed [PixW:0]   w_m    [Lanes];
    logic signed [ProdW-1:0] w_prod [Lanes];
    logic signed [AccW-1:0] n_acc  [Lanes];
    logic [PixW-1:0]        w_sat  [Lanes];

    logic                   r_s1_valid;
    pcpo_pkg::t_op          r_s1_op;
    logic signed [AccW-1:0] r_s1_acc [Lanes];
    logic [PixW-1:0]        r_s1_alpha;
    logic                   r_s1_last;
    logic [PixW-1:0]        r_rd_red;
    logic [PixW-1:0]        r_rd_green;
    logic [PixW-1:0]        r_rd_blue;

    logic                   r_out_valid;
    logic [PixW-1:0]        r_red;
    logic [PixW-1:0]        r_green;
    logic [PixW-1:0]        r_blue;
    logic [PixW-1:0]        r_alpha;
    logic                   r_last;
    logic [PixW-1:0]        n_red;
    logic [PixW-1:0]        n_green;
    logic [PixW-1:0]        n_blue;
    logic [PixW-1:0]        n_alpha;

    assign w_adv   = !r_out_valid || !i_out_stall;
    assign o_q_pop = i_q_valid && w_adv;
    assign w_wr    = o_q_pop && (i_q_data.op == pcpo_pkg::OP_WRITE);

    // lanes: red, green, blue, alpha
    assign w_x[0] = i_q_data.red;
    assign w_x[1] = i_q_data.green;
    assign w_x[2] = i_q_data.blue;
    assign w_x[3] = i_q_data.alpha;
    assign w_g[0] = i_cfg.gain_red;
    assign w_g[1] = i_cfg.gain_green;
    assign w_g[2] = i_cfg.gain_blue;
    assign w_g[3] = i_cfg.gain_alpha;

    always_comb begin
        for (int i = 0; i < Lanes; i++) begin
            if (i_q_data.op == pcpo_pkg::OP_CONTRAST && i != Lanes - 1) begin
                w_m[i] = $signed({1'b0, w_x[i]}) - $signed((PixW + 1)'(128));
            end else begin
                w_m[i] = $signed({1'b0, w_x[i]});
            end
            w_prod[i] = w_m[i] * w_g[i];
            if (i_q_data.op == pcpo_pkg::OP_OFFSET && i != Lanes - 1) begin
                n_acc[i] = $signed(AccW'({w_x[i], {GainFracBits{1'b0}}}))
                         + AccW'(w_g[i]);
            end else if (i_q_data.op == pcpo_pkg::OP_CONTRAST && i != Lanes - 1) begin
                n_acc[i] = AccW'(w_prod[i]) + $signed(AccW'(128) << GainFracBits);
            end else begin
                n_acc[i] = AccW'(w_prod[i]);
            end
        end
    end

    // truncate and clamp to 0..255
    always_comb begin
        for (int i = 0; i < Lanes; i++) begin
            if (r_s1_acc[i] <= 0) begin
                w_sat[i] = '0;
            end else if (|r_s1_acc[i][AccW-1:GainFracBits+PixW]) begin
                w_sat[i] = '1;
            end else begin
                w_sat[i] = r_s1_acc[i][GainFracBits+PixW-1:GainFracBits];
            end
        end
    end

    always_comb begin
        if (r_s1_op == pcpo_pkg::OP_LUT) begin
            n_red   = r_rd_red;
            n_green = r_rd_green;
            n_blue  = r_rd_blue;
        end else begin
            n_red   = w_sat[0];
            n_green = w_sat[1];
            n_blue  = w_sat[2];
        end
        if (!i_cfg.has_alpha) begin
            n_alpha = '0;
        end else if (r_s1_op == pcpo_pkg::OP_SCALE) begin
            n_alpha = w_sat[3];
        end else begin
            n_alpha = r_s1_alpha;
        end
    end

    // table write
    always_ff @(posedge i_clk) begin
        if (w_wr && i_q_data.tbl_channel == pcpo_pkg::CH_RED) begin
            r_tbl_red[i_q_data.tbl_index] <= i_q_data.tbl_value;
        end
        if (w_wr && i_q_data.tbl_channel == pcpo_pkg::CH_GREEN) begin
            r_tbl_green[i_q_data.tbl_index] <= i_q_data.tbl_value;
        end
        if (w_wr && i_q_data.tbl_channel == pcpo_pkg::CH_BLUE) begin
            r_tbl_blue[i_q_data.tbl_index] <= i_q_data.tbl_value;
        end
    end

    // table read and arithmetic stage
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd_red   <= r_tbl_red[i_q_data.red];
            r_rd_green <= r_tbl_green[i_q_data.green];
            r_rd_blue  <= r_tbl_blue[i_q_data.blue];
            r_s1_op    <= i_q_data.op;
            r_s1_alpha <= i_q_data.alpha;
            r_s1_last  <= i_q_data.last;
            for (int i = 0; i < Lanes; i++) begin
                r_s1_acc[i] <= n_acc[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_alpha <= n_alpha;
            r_last  <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= o_q_pop && (i_q_data.op != pcpo_pkg::OP_WRITE);
            r_out_valid <= r_s1_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;
    assign o_alpha_out = r_alpha;
    assign o_last_out  = r_last;

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> !r_s1_valid)
        else $error("table write produced a result");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && i_out_stall |=> r_s1_valid && r_out_valid)
        else $error("pixel dropped while output stalled");

endmodule

FILE: rtl/core/pixel_color_point_ops_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_color_point_ops_top
// Per-pixel color point operation: table lookup, gain, offset or contrast.
// ----------------------------------------------------------------------------
// path: from input accept to output valid through the front register, the
//   queue, the multiply and table read stage, then saturate into output register
// throughput: one request per cycle unless output stalls, set by the single multiply stage per lane
// reset: synchronous active low, clears control state and loads register
//   defaults; the lookup tables hold no reset value and must be written first
// ----------------------------------------------------------------------------
module pixel_color_point_ops_top #(
    parameter int GainFracBits = pcpo_pkg::GAIN_FRAC_BITS,
    parameter int QueueDepth   = pcpo_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcpo_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pcpo_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pcpo_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic [pcpo_pkg::PIX_W-1:0]        i_red_in,
    input  logic [pcpo_pkg::PIX_W-1:0]        i_green_in,
    input  logic [pcpo_pkg::PIX_W-1:0]        i_blue_in,
    input  logic [pcpo_pkg::PIX_W-1:0]        i_alpha_in,
    input  logic                              i_frame_end,
    input  logic [1:0]                        i_table_channel,
    input  logic [pcpo_pkg::PIX_W-1:0]        i_table_index,
    input  logic [pcpo_pkg::PIX_W-1:0]        i_table_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [pcpo_pkg::PIX_W-1:0]        o_red_out,
    output logic [pcpo_pkg::PIX_W-1:0]        o_green_out,
    output logic [pcpo_pkg::PIX_W-1:0]        o_blue_out,
    output logic [pcpo_pkg::PIX_W-1:0]        o_alpha_out,
    output logic                              o_last_out
);

    pcpo_pkg::t_cfg w_cfg;
    logic           w_q_full;
    logic           w_q_push;
    pcpo_pkg::t_req w_q_wdata;
    logic           w_q_valid;
    logic           w_q_pop;
    pcpo_pkg::t_req w_q_rdata;

    pcpo_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pcpo_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_red_in        (i_red_in),
        .i_green_in      (i_green_in),
        .i_blue_in       (i_blue_in),
        .i_alpha_in      (i_alpha_in),
        .i_frame_end     (i_frame_end),
        .i_table_channel (i_table_channel),
        .i_table_index   (i_table_index),
        .i_table_value   (i_table_value),
        .i_op_mode       (w_cfg.op_mode),
        .i_q_full        (w_q_full),
        .o_q_push        (w_q_push),
        .o_q_data        (w_q_wdata)
    );

    pcpo_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata)
    );

    pcpo_back #(
        .GainFracBits (GainFracBits)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_rdata),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_alpha_out (o_alpha_out),
        .o_last_out  (o_last_out)
    );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pixel_color_point_ops_top. A behavioral point-op
// predictor tracks the registers and the three lookup tables and queues the
// expected output of every accepted pixel. Covers table writes, every mode,
// gain extremes, RGB and RGBA pixels, and random input gaps and output stalls,
// plus a long output hold that fills the block.
// ----------------------------------------------------------------------------
module testbench;
    import pcpo_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 100;
    localparam int HOLD_ITEMS   = 40;
    localparam int MAX_PRINTS   = 50;

    typedef struct {
        logic             cmd;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic             last;
        logic [1:0]       channel;
        logic [PIX_W-1:0] index;
        logic [PIX_W-1:0] value;
    } t_pixel_req;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic             last;
    } t_pixel_out;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0] paddr           = '0;
    logic [APB_DATA_W-1:0] pwdata          = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic                  i_command       = CMD_PIXEL;
    logic [PIX_W-1:0]      i_red_in        = '0;
    logic [PIX_W-1:0]      i_green_in      = '0;
    logic [PIX_W-1:0]      i_blue_in       = '0;
    logic [PIX_W-1:0]      i_alpha_in      = '0;
    logic                  i_frame_end     = 1'b0;
    logic [1:0]            i_table_channel = CH_RED;
    logic [PIX_W-1:0]      i_table_index   = '0;
    logic [PIX_W-1:0]      i_table_value   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic [PIX_W-1:0]      o_red_out;
    logic [PIX_W-1:0]      o_green_out;
    logic [PIX_W-1:0]      o_blue_out;
    logic [PIX_W-1:0]      o_alpha_out;
    logic                  o_last_out;

    // predictor state
    logic [1:0]               cfg_mode       = OP_MODE_RESET;
    logic                     cfg_has_alpha  = HAS_ALPHA_RESET;
    logic signed [GAIN_W-1:0] cfg_gain_red   = GAIN_RESET;
    logic signed [GAIN_W-1:0] cfg_gain_green = GAIN_RESET;
    logic signed [GAIN_W-1:0] cfg_gain_blue  = GAIN_RESET;
    logic signed [GAIN_W-1:0] cfg_gain_alpha = GAIN_RESET;
    logic [PIX_W-1:0]         lut_mem [3][TABLE_DEPTH];
    bit                       lut_written [3][TABLE_DEPTH];
    logic [PIX_W-1:0]         lut_filled [3][$];
    t_pixel_out               pixel_results_due [$];

    int errors         = 0;
    int cycle_count    = 0;
    int hold_requests  = 0;
    int holds_started  = 0;
    int hold_left      = 0;
    bit idle_on        = 1'b1;

    pixel_color_point_ops_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_red_in        (i_red_in),
        .i_green_in      (i_green_in),
        .i_blue_in       (i_blue_in),
        .i_alpha_in      (i_alpha_in),
        .i_frame_end     (i_frame_end),
        .i_table_channel (i_table_channel),
        .i_table_index   (i_table_index),
        .i_table_value   (i_table_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_red_out       (o_red_out),
        .o_green_out     (o_green_out),
        .o_blue_out      (o_blue_out),
        .o_alpha_out     (o_alpha_out),
        .o_last_out      (o_last_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [PIX_W-1:0] saturate_byte(longint fx);
        longint q;
        if (fx <= 0) return '0;
        q = fx >>> GAIN_FRAC_BITS;
        return (q > 255) ? 8'hff : q[PIX_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] point_op_channel(logic [1:0] mode,
                                                          logic [PIX_W-1:0] x,
                                                          logic signed [GAIN_W-1:0] g);
        longint v;
        longint gl;
        longint one;
        v   = longint'(x);
        gl  = longint'(g);
        one = longint'(1) << GAIN_FRAC_BITS;
        case (mode)
            MODE_SCALE:  return saturate_byte(v * gl);
            MODE_OFFSET: return saturate_byte(v * one + gl);
            default:     return saturate_byte((v - 128) * gl + 128 * one);
        endcase
    endfunction

    task automatic apply_request(t_pixel_req req);
        t_pixel_out res;
        if (req.cmd == CMD_WRITE) begin
            case (req.channel)
                CH_RED, CH_GREEN, CH_BLUE: begin
                    lut_mem[req.channel][req.index] = req.value;
                    if (!lut_written[req.channel][req.index]) begin
                        lut_written[req.channel][req.index] = 1'b1;
                        lut_filled[req.channel].push_back(req.index);
                    end
                end
                default: ;
            endcase
            return;
        end
        if (cfg_mode == MODE_LUT) begin
            res.red   = lut_mem[CH_RED][req.red];
            res.green = lut_mem[CH_GREEN][req.green];
            res.blue  = lut_mem[CH_BLUE][req.blue];
            res.alpha = req.alpha;
        end else begin
            res.red   = point_op_channel(cfg_mode, req.red, cfg_gain_red);
            res.green = point_op_channel(cfg_mode, req.green, cfg_gain_green);
            res.blue  = point_op_channel(cfg_mode, req.blue, cfg_gain_blue);
            res.alpha = (cfg_mode == MODE_SCALE) ?
                        point_op_channel(MODE_SCALE, req.alpha, cfg_gain_alpha) : req.alpha;
        end
        if (!cfg_has_alpha) res.alpha = '0;
        res.last = req.last;
        pixel_results_due.push_back(res);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        if (errors < MAX_PRINTS)
            $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want,
                     cycle_count);
        errors++;
    endtask

    function automatic t_pixel_req make_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                              logic [PIX_W-1:0] b, logic [PIX_W-1:0] a,
                                              logic last);
        t_pixel_req req;
        req.cmd     = CMD_PIXEL;
        req.red     = r;
        req.green   = g;
        req.blue    = b;
        req.alpha   = a;
        req.last    = last;
        req.channel = 2'($urandom);
        req.index   = 8'($urandom);
        req.value   = 8'($urandom);
        return req;
    endfunction

    function automatic t_pixel_req make_write(logic [1:0] ch, logic [PIX_W-1:0] idx,
                                              logic [PIX_W-1:0] val);
        t_pixel_req req;
        req         = make_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                 1'($urandom));
        req.cmd     = CMD_WRITE;
        req.channel = ch;
        req.index   = idx;
        req.value   = val;
        return req;
    endfunction

    function automatic logic [PIX_W-1:0] pick_filled(logic [1:0] ch);
        return lut_filled[ch][$urandom_range(0, lut_filled[ch].size() - 1)];
    endfunction

    function automatic t_pixel_req random_request();
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        if ($urandom_range(0, 99) < 18)
            return make_write(2'($urandom), 8'($urandom), 8'($urandom));
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        if (cfg_mode == MODE_LUT) begin
            r = pick_filled(CH_RED);
            g = pick_filled(CH_GREEN);
            b = pick_filled(CH_BLUE);
        end
        return make_pixel(r, g, b, 8'($urandom), $urandom_range(0, 15) == 0);
    endfunction

    function automatic logic signed [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '0;
            3, 4:    return 16'($urandom);
            default: return 16'($urandom_range(0, 640)) - 16'sd64;
        endcase
    endfunction

    task automatic send_request(t_pixel_req req);
        if (idle_on && $urandom_range(0, 99) < 8) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_command       <= req.cmd;
        i_red_in        <= req.red;
        i_green_in      <= req.green;
        i_blue_in       <= req.blue;
        i_alpha_in      <= req.alpha;
        i_frame_end     <= req.last;
        i_table_channel <= req.channel;
        i_table_index   <= req.index;
        i_table_value   <= req.value;
        i_in_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_request(req);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pixel_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx r, logic [APB_DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (r)
            REG_OP_MODE:    cfg_mode       = v[1:0];
            REG_HAS_ALPHA:  cfg_has_alpha  = v[0];
            REG_GAIN_RED:   cfg_gain_red   = v[GAIN_W-1:0];
            REG_GAIN_GREEN: cfg_gain_green = v[GAIN_W-1:0];
            REG_GAIN_BLUE:  cfg_gain_blue  = v[GAIN_W-1:0];
            REG_GAIN_ALPHA: cfg_gain_alpha = v[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [1:0] mode, logic alpha,
                              logic signed [GAIN_W-1:0] gr, logic signed [GAIN_W-1:0] gg,
                              logic signed [GAIN_W-1:0] gb, logic signed [GAIN_W-1:0] ga);
        cfg_write(REG_OP_MODE, {30'd0, mode});
        cfg_write(REG_HAS_ALPHA, {31'd0, alpha});
        cfg_write(REG_GAIN_RED, {16'd0, gr});
        cfg_write(REG_GAIN_GREEN, {16'd0, gg});
        cfg_write(REG_GAIN_BLUE, {16'd0, gb});
        cfg_write(REG_GAIN_ALPHA, {16'd0, ga});
    endtask

    task automatic test_default_scale();
        send_request(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_request(make_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
        send_request(make_pixel(8'h80, 8'h01, 8'hfe, 8'h7f, 1'b0));
        wait_drain();
    endtask

    task automatic test_table_lookup();
        send_request(make_write(CH_RED, 8'h00, 8'hff));
        send_request(make_write(CH_RED, 8'hff, 8'h00));
        send_request(make_write(CH_GREEN, 8'h00, 8'h5a));
        send_request(make_write(CH_GREEN, 8'hff, 8'ha5));
        send_request(make_write(CH_BLUE, 8'h00, 8'h01));
        send_request(make_write(CH_BLUE, 8'hff, 8'hfe));
        // unknown channel must leave every table untouched
        send_request(make_write(2'd3, 8'h00, 8'h33));
        wait_drain();
        cfg_write(REG_OP_MODE, {30'd0, MODE_LUT});
        send_request(make_pixel(8'h00, 8'hff, 8'h00, 8'h09, 1'b1));
        send_request(make_pixel(8'hff, 8'h00, 8'hff, 8'hc8, 1'b0));
        wait_drain();
    endtask

    task automatic test_gain_limits();
        set_config(MODE_SCALE, 1'b1, 16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff);
        send_request(make_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b0));
        send_request(make_pixel(8'h01, 8'h01, 8'h01, 8'h01, 1'b1));
        wait_drain();
        set_config(MODE_OFFSET, 1'b1, 16'sh7fff, 16'sh8000, 16'sh0080, 16'sh0100);
        send_request(make_pixel(8'hc8, 8'hc8, 8'hc8, 8'h4d, 1'b1));
        wait_drain();
        set_config(MODE_CONTRAST, 1'b0, 16'sh7fff, 16'sh8000, 16'sh0080, 16'sh7fff);
        send_request(make_pixel(8'h00, 8'hff, 8'h80, 8'hff, 1'b0));
        send_request(make_pixel(8'hff, 8'h00, 8'h7f, 8'h03, 1'b1));
        wait_drain();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < PHASES; p++) begin
            set_config(2'(p % 4), 1'($urandom), rand_gain(), rand_gain(), rand_gain(),
                       rand_gain());
            idle_on = (p != 6);
            for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
            wait_drain();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_output_hold();
        set_config(MODE_CONTRAST, 1'b1, rand_gain(), rand_gain(), rand_gain(), rand_gain());
        hold_requests++;
        for (int n = 0; n < HOLD_ITEMS; n++) send_request(random_request());
        wait_drain();
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_requests != holds_started) begin
            holds_started <= holds_started + 1;
            hold_left     <= HOLD_CYCLES;
            i_out_stall   <= 1'b1;
        end else begin
            i_out_stall <= idle_on && ($urandom_range(0, 99) < 8);
        end
    end

    always @(posedge i_clk) begin
        t_pixel_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pixel_results_due.size() == 0) begin
                report_mismatch("output with no pixel pending", 0, 0);
            end else begin
                want = pixel_results_due.pop_front();
                if (o_red_out !== want.red) report_mismatch("red_out", o_red_out, want.red);
                if (o_green_out !== want.green)
                    report_mismatch("green_out", o_green_out, want.green);
                if (o_blue_out !== want.blue)
                    report_mismatch("blue_out", o_blue_out, want.blue);
                if (o_alpha_out !== want.alpha)
                    report_mismatch("alpha_out", o_alpha_out, want.alpha);
                if (o_last_out !== want.last)
                    report_mismatch("last_out", o_last_out, want.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_scale();
        test_table_lookup();
        test_gain_limits();
        test_random_settings();
        test_output_hold();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
